[design/owdm_pkg.sv]
// Shared types, constants and the quarter-wave sine table for the omni wheel drive mixer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package owdm_pkg;

  localparam int NUM_WHEELS = 4;
  localparam int Q_BITS     = 14;
  localparam int MAG_W      = 15;
  localparam int REM_W      = MAG_W + Q_BITS;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = MAG_W / DIV_STEPS;
  localparam int PMAG_W     = 9;
  localparam int POW_W      = 11;

  localparam logic [7:0]       DUTY_MAX = 8'd255;
  localparam logic [MAG_W-1:0] Q_ONE    = 15'd16384;

  localparam logic [8:0] FULL_TURN    = 9'd360;
  localparam logic [8:0] QUARTER_TURN = 9'd90;
  localparam logic [8:0] HALF_TURN    = 9'd180;
  localparam logic [8:0] THREE_QUARTER = 9'd270;

  // Wheel mount angles 40, 140, 225 and 315 degrees, folded together with the
  // 450 degree direction map and the sign flip into one offset per wheel.
  localparam logic [8:0] WHEEL_OFFSET [NUM_WHEELS] = '{9'd230, 9'd130, 9'd45, 9'd315};

  localparam logic [8:0] ROT_LOW   = 9'd45;
  localparam logic [8:0] ROT_HIGH  = 9'd315;
  localparam logic [8:0] TRIM_LOW  = 9'd10;
  localparam logic [8:0] TRIM_HIGH = 9'd350;

  localparam logic [7:0]       ROTATE_POWER = 8'd100;
  localparam logic [POW_W-1:0] TRIM_POWER   = 11'd10;

  localparam logic [MAG_W-1:0] SINE_Q [0:90] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  typedef enum logic [1:0] {
    TRIM_NONE = 2'b00,
    TRIM_NEG  = 2'b01,
    TRIM_POS  = 2'b10
  } trim_t;

  typedef struct packed {
    logic  rot;
    logic  rot_neg;
    trim_t trim;
  } mode_t;

  typedef struct packed {
    logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;
    logic [NUM_WHEELS-1:0]            neg;
    logic [MAG_W-1:0]                 mx;
    logic                             norm;
    mode_t                            mode;
  } mix_t;

  typedef struct packed {
    mix_t                             mix;
    logic [NUM_WHEELS-1:0][MAG_W-1:0] quo;
  } quot_t;

endpackage

`default_nettype wire

[design/owdm_front.sv]
// Front end: angle reduction, heading decode, sine lookup and maximum search.
// Two register stages; depends on owdm_pkg.
`default_nettype none

module owdm_front import owdm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [8:0] travel_angle,
  input  wire logic [8:0] heading,
  output logic            out_valid,
  input  wire logic       out_ready,
  output mix_t            out_mix
);

  logic                        va, vb;
  logic                        en_a, en_b;
  logic [NUM_WHEELS-1:0][6:0]  ka, ka_next;
  logic [NUM_WHEELS-1:0]       na, na_next;
  mode_t                       mode_a, mode_a_next;
  mix_t                        mix_b, mix_b_next;

  assign en_b     = !vb || out_ready;
  assign en_a     = !va || en_b;
  assign in_ready = en_a;

  // Stage A: fold each wheel angle into a quarter-wave index and a sign, and decode the heading.
  always_comb begin
    logic [8:0] t;
    logic [9:0] e10;
    logic [8:0] e;
    t = (travel_angle >= FULL_TURN) ? travel_angle - FULL_TURN : travel_angle;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if (WHEEL_OFFSET[i] >= t) begin
        e10 = {1'b0, WHEEL_OFFSET[i]} - {1'b0, t};
      end else begin
        e10 = {1'b0, WHEEL_OFFSET[i]} + {1'b0, FULL_TURN} - {1'b0, t};
      end
      e = e10[8:0];
      if (e <= QUARTER_TURN) begin
        ka_next[i] = e[6:0];
        na_next[i] = 1'b0;
      end else if (e <= HALF_TURN) begin
        ka_next[i] = 7'(HALF_TURN - e);
        na_next[i] = 1'b0;
      end else if (e <= THREE_QUARTER) begin
        ka_next[i] = 7'(e - HALF_TURN);
        na_next[i] = 1'b1;
      end else begin
        ka_next[i] = 7'(FULL_TURN - e);
        na_next[i] = 1'b1;
      end
    end
    mode_a_next.rot     = (heading > ROT_LOW) && (heading < ROT_HIGH);
    mode_a_next.rot_neg = heading < HALF_TURN;
    if (heading >= TRIM_LOW && heading < HALF_TURN) begin
      mode_a_next.trim = TRIM_NEG;
    end else if (heading >= HALF_TURN && heading < TRIM_HIGH) begin
      mode_a_next.trim = TRIM_POS;
    end else begin
      mode_a_next.trim = TRIM_NONE;
    end
  end

  // Stage B: table lookup and the largest signed factor.
  always_comb begin
    logic signed [MAG_W:0] fac [NUM_WHEELS];
    logic signed [MAG_W:0] m01, m23, mx;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      mix_b_next.mag[i] = SINE_Q[ka[i]];
      mix_b_next.neg[i] = na[i];
      fac[i] = na[i] ? -$signed({1'b0, SINE_Q[ka[i]]}) : $signed({1'b0, SINE_Q[ka[i]]});
    end
    m01 = (fac[1] > fac[0]) ? fac[1] : fac[0];
    m23 = (fac[3] > fac[2]) ? fac[3] : fac[2];
    mx  = (m23 > m01) ? m23 : m01;
    mix_b_next.mx   = mx[MAG_W-1:0];
    mix_b_next.norm = (mx > 0) && (mx < $signed({1'b0, Q_ONE}));
    mix_b_next.mode = mode_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (en_a) va <= in_valid;
      if (en_b) vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      ka     <= ka_next;
      na     <= na_next;
      mode_a <= mode_a_next;
    end
    if (en_b && va) begin
      mix_b <= mix_b_next;
    end
  end

  assign out_valid = vb;
  assign out_mix   = mix_b;

endmodule

`default_nettype wire

[design/owdm_div.sv]
// Pipelined restoring divider, four lanes, three quotient bits per stage.
// Divides each factor magnitude scaled by 2^14 by the maximum; depends on owdm_pkg.
`default_nettype none

module owdm_div import owdm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire mix_t in_mix,
  output logic      out_valid,
  input  wire logic out_ready,
  output quot_t     out_quot
);

  logic [DIV_STAGES-1:0]             v;
  logic [DIV_STAGES-1:0]             en;
  mix_t                              mix_r [DIV_STAGES];
  logic [NUM_WHEELS-1:0][REM_W-1:0]  rem_r [DIV_STAGES];
  logic [NUM_WHEELS-1:0][MAG_W-1:0]  quo_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic                              src_v;
    mix_t                              src_mix;
    logic [NUM_WHEELS-1:0][REM_W-1:0]  src_rem, rem_next;
    logic [NUM_WHEELS-1:0][MAG_W-1:0]  src_quo, quo_next;

    if (s == 0) begin : g_first
      assign src_v   = in_valid;
      assign src_mix = in_mix;
      for (genvar l = 0; l < NUM_WHEELS; l++) begin : g_lane
        assign src_rem[l] = {in_mix.mag[l], {Q_BITS{1'b0}}};
        assign src_quo[l] = '0;
      end
    end else begin : g_rest
      assign src_v   = v[s-1];
      assign src_mix = mix_r[s-1];
      assign src_rem = rem_r[s-1];
      assign src_quo = quo_r[s-1];
    end

    if (s == DIV_STAGES - 1) begin : g_last_en
      assign en[s] = !v[s] || out_ready;
    end else begin : g_mid_en
      assign en[s] = !v[s] || en[s+1];
    end

    always_comb begin
      logic [REM_W-1:0] d;
      rem_next = src_rem;
      quo_next = src_quo;
      for (int l = 0; l < NUM_WHEELS; l++) begin
        for (int j = 0; j < DIV_STEPS; j++) begin
          d = REM_W'(src_mix.mx) << (MAG_W - 1 - s * DIV_STEPS - j);
          if (rem_next[l] >= d) begin
            rem_next[l] = rem_next[l] - d;
            quo_next[l][MAG_W - 1 - s * DIV_STEPS - j] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en[s]) begin
        v[s] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en[s] && src_v) begin
        mix_r[s] <= src_mix;
        rem_r[s] <= rem_next;
        quo_r[s] <= quo_next;
      end
    end
  end

  assign in_ready      = en[0];
  assign out_valid     = v[DIV_STAGES-1];
  assign out_quot.mix  = mix_r[DIV_STAGES-1];
  assign out_quot.quo  = quo_r[DIV_STAGES-1];

endmodule

`default_nettype wire

[design/owdm_back.sv]
// Back end: base speed scaling, heading trim, rotate override and H-bridge pin encoding.
// Two register stages, the second being the output register; depends on owdm_pkg.
`default_nettype none

module owdm_back import owdm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  base_speed,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire quot_t       in_quot,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_pins,
  output logic             out_rot
);

  logic                              vc, vd;
  logic                              en_c, en_d;
  logic [NUM_WHEELS-1:0][PMAG_W-1:0] pmag, pmag_next;
  logic [NUM_WHEELS-1:0]             neg_c;
  mode_t                             mode_c;
  logic [63:0]                       pins, pins_next;
  logic                              rot;

  assign en_d     = !vd || out_ready;
  assign en_c     = !vc || en_d;
  assign in_ready = en_c;

  // Magnitudes are scaled here; the sign is applied afterward so the shift
  // truncates toward zero.
  always_comb begin
    logic [MAG_W-1:0]       sel;
    logic [MAG_W+7:0]       prod;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      sel  = in_quot.mix.norm ? in_quot.quo[i] : in_quot.mix.mag[i];
      prod = {{MAG_W{1'b0}}, base_speed} * {8'b0, sel};
      pmag_next[i] = prod[Q_BITS +: PMAG_W];
    end
  end

  always_comb begin
    logic signed [POW_W-1:0] p;
    logic [POW_W-1:0]        m;
    logic [7:0]              a, b;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      p = '0;
      m = '0;
      if (mode_c.rot) begin
        a = mode_c.rot_neg ? ROTATE_POWER : 8'd0;
        b = mode_c.rot_neg ? 8'd0 : ROTATE_POWER;
      end else begin
        p = neg_c[i] ? -$signed({2'b0, pmag[i]}) : $signed({2'b0, pmag[i]});
        case (mode_c.trim)
          TRIM_NEG: p = p - $signed(TRIM_POWER);
          TRIM_POS: p = p + $signed(TRIM_POWER);
          default:  p = p;
        endcase
        if (p < 0) begin
          m = POW_W'(-p);
          a = (m > POW_W'(DUTY_MAX)) ? DUTY_MAX : m[7:0];
          b = 8'd0;
        end else if (p > 0) begin
          m = POW_W'(p);
          a = 8'd0;
          b = (m > POW_W'(DUTY_MAX)) ? DUTY_MAX : m[7:0];
        end else begin
          a = DUTY_MAX;
          b = DUTY_MAX;
        end
      end
      pins_next[16*i +: 8]     = a;
      pins_next[16*i + 8 +: 8] = b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      if (en_c) vc <= in_valid;
      if (en_d) vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && in_valid) begin
      pmag   <= pmag_next;
      neg_c  <= in_quot.mix.neg;
      mode_c <= in_quot.mix.mode;
    end
    if (en_d && vc) begin
      pins <= pins_next;
      rot  <= mode_c.rot;
    end
  end

  assign out_valid = vd;
  assign out_pins  = pins;
  assign out_rot   = rot;

endmodule

`default_nettype wire

[design/omni_wheel_drive_mixer.sv]
// Throughput: one beat per cycle while the output is ready; the nine-stage pipeline (two front,
// five divider, two back) compresses bubbles, so a stalled output only blocks as far as stages are full.
// Reset: rst, synchronous and active high, empties the pipeline and clears base_speed.
// Depends on owdm_pkg, owdm_front, owdm_div and owdm_back.
`default_nettype none

module omni_wheel_drive_mixer import owdm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: base_speed, one register, written whenever a beat arrives.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [8:0] travel_angle, [17:9] heading, [23:18] zero
  // Output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // wheel1_pin_a, wheel1_pin_b, ... wheel4_pin_b, 8 bits each
  output logic             m_tuser    // rotating
);

  logic [7:0] base_speed;
  logic       f_valid, f_ready;
  mix_t       f_mix;
  logic       d_valid, d_ready;
  quot_t      d_quot;

  // The base speed is to be changed only while the block is idle; the user is bound by this,
  // the block itself does not enforce it. The back end reads it directly without a pipeline copy.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_speed <= 8'd0;
    end else if (cfg_valid) begin
      base_speed <= cfg_data;
    end
  end

  // The front end reduces angles, looks up the four wheel factors and finds
  // their maximum. The divider then rescales each factor by 1/max, and the back
  // end applies the base speed, the heading trim and the rotate override.
  owdm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .travel_angle (s_tdata[8:0]),
    .heading      (s_tdata[17:9]),
    .out_valid    (f_valid),
    .out_ready    (f_ready),
    .out_mix      (f_mix)
  );

  owdm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_mix    (f_mix),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_quot  (d_quot)
  );

  owdm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .base_speed (base_speed),
    .in_valid   (d_valid),
    .in_ready   (d_ready),
    .in_quot    (d_quot),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_pins   (m_tdata),
    .out_rot    (m_tuser)
  );

`ifndef SYNTHESIS
  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat valid right after reset");

  // A rotate command drives wheel 1 at the rotate power in one direction.
  a_rotate_pins: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      (m_tdata[7:0] == ROTATE_POWER && m_tdata[15:8] == 8'd0) ||
      (m_tdata[7:0] == 8'd0 && m_tdata[15:8] == ROTATE_POWER))
    else $error("rotate beat without rotate power on wheel 1");

  // All four wheels agree in a rotate command.
  a_rotate_same: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      m_tdata[15:0] == m_tdata[31:16] && m_tdata[15:0] == m_tdata[47:32] &&
      m_tdata[15:0] == m_tdata[63:48])
    else $error("rotate beat with differing wheels");

  // The wheel 1 bridge never drives both pins unless it brakes.
  a_bridge_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:0] == 8'd0 || m_tdata[15:8] == 8'd0 ||
      (m_tdata[7:0] == DUTY_MAX && m_tdata[15:8] == DUTY_MAX))
    else $error("wheel 1 bridge drives both pins");
`endif

endmodule

`default_nettype wire
